// ----- hdl/respiratory_flow_volume_tracker_unit_assert.svh -----
// Assertion macros for the respiratory flow volume tracker checker.
// Depends on nothing; included by files that assert.
`ifndef RESPIRATORY_FLOW_VOLUME_TRACKER_UNIT_ASSERT_SVH
`define RESPIRATORY_FLOW_VOLUME_TRACKER_UNIT_ASSERT_SVH
// condition holds at every edge out of reset
`define RFVT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rfvt check failed");
// antecedent implies consequent at the next clock edge
`define RFVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfvt check failed");
`endif

// ----- hdl/rfvt_pkg.sv -----
// Shared types, constants and helpers of the respiratory flow volume tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rfvt_pkg;
    localparam int unsigned VOL_W   = 48;
    localparam int unsigned FLOW_W  = 25;
    localparam int unsigned VENT_W  = 24;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned DIVN_W  = 50;
    localparam int unsigned DIVD_W  = 25;
    localparam int unsigned ITER_W  = 6;
    localparam int unsigned CONV_ITERS = 24;
    localparam logic [23:0] FLOW_LIMIT = 24'd8388608;
    localparam logic [31:0] MAX_GAP_MS = 32'd1000;
    localparam logic [VENT_W-1:0] MAX_VENT = '1;

    localparam logic [CIDX_W-1:0] CFG_ZERO_OFFSET = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_FLOW_SCALE  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_PHASE_THR   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_DEADBAND    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_BUCKET_MS   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_WINDOW_MS   = 3'd5;

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_INHALE = 2'd1;
    localparam logic [1:0] PHASE_EXHALE = 2'd2;

    typedef struct packed {
        logic                start;
        logic [ITER_W-1:0]   iters;
        logic [DIVN_W-1:0]   dividend;
        logic [DIVD_W-1:0]   divisor;
    } t_div_req;

    function automatic logic [VOL_W-1:0] sat_add48(input logic [VOL_W-1:0] a,
                                                   input logic [VOL_W-1:0] b);
        logic [VOL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VOL_W] ? '1 : s[VOL_W-1:0];
    endfunction

    function automatic logic [VOL_W-1:0] floor_sub48(input logic [VOL_W-1:0] a,
                                                     input logic [VOL_W-1:0] b);
        return (b > a) ? '0 : a - b;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/rfvt_in_if.sv -----
// Input channel of the tracker: valid/ready with one sample or reset beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rfvt_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] raw_sample;
    logic [31:0] time_ms;
    modport source(output valid, action, raw_sample, time_ms, input ready);
    modport sink(input valid, action, raw_sample, time_ms, output ready);
endinterface
`default_nettype wire

// ----- hdl/rfvt_out_if.sv -----
// Result channel of the tracker: valid/ready with one result beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rfvt_out_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] flow;
    logic [47:0]        inhale_volume;
    logic [47:0]        exhale_volume;
    logic [23:0]        ventilation;
    logic [1:0]         breath_phase;
    modport source(output valid, flow, inhale_volume, exhale_volume, ventilation,
                   breath_phase, input ready);
    modport sink(input valid, flow, inhale_volume, exhale_volume, ventilation,
                 breath_phase, output ready);
endinterface
`default_nettype wire

// ----- hdl/rfvt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rfvt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/rfvt_div.sv -----
// Bit-serial restoring divider shared by flow conversion and ventilation.
// Depends on rfvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rfvt_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rfvt_pkg::t_div_req          i_req,
    output      logic                        o_done,
    output      logic [rfvt_pkg::DIVN_W-1:0] o_quot
);
    import rfvt_pkg::*;

    logic [DIVD_W:0]   r_rem;
    logic [DIVN_W-1:0] r_q;
    logic [DIVD_W-1:0] r_den;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic [DIVD_W:0]   n_trial;
    logic              n_fit;

    assign n_trial = {r_rem[DIVD_W-1:0], r_q[DIVN_W-1]};
    assign n_fit   = n_trial >= {1'b0, r_den};
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
                r_rem  <= '0;
                r_q    <= i_req.dividend;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_fit ? n_trial - {1'b0, r_den} : n_trial;
                r_q   <= {r_q[DIVN_W-2:0], n_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/respiratory_flow_volume_tracker_unit.sv -----
// Respiratory flow volume tracker. Each input beat takes one sample or reset
// action and returns one result beat. A reset action needs no divide; a sample
// runs the 24-step serial conversion divide and, when ventilation is computed,
// also the 50-step serial ventilation divide, both through the one shared
// bit-serial divider. One item at a time; configuration writes are taken at
// any time but belong to idle periods.
`timescale 1ns / 1ps
`default_nettype none
module respiratory_flow_volume_tracker_unit #(
    parameter int BUCKETS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [rfvt_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  wire logic [rfvt_pkg::CFG_W-1:0]   i_cfg_data,
    rfvt_in_if.sink                           i_in,
    rfvt_out_if.source                        o_out
);
    import rfvt_pkg::*;

    localparam int HW = $clog2(BUCKETS);

    typedef enum logic [3:0] {
        S_IDLE, S_CONV, S_ACC, S_CMP, S_CMT, S_SUM, S_ADD, S_VST, S_VDIV, S_OUT
    } t_state;

    t_state r_state;

    logic [15:0] r_zero_offset, r_flow_scale, r_phase_thr, r_deadband, r_bucket_ms;
    logic [23:0] r_window_ms;

    logic                r_neg;
    logic [31:0]         r_now;
    logic                r_primed;
    logic [31:0]         r_last_time;
    logic signed [FLOW_W-1:0] r_last_flow;
    logic [1:0]          r_phase;
    logic [VOL_W-1:0]    r_inh_tot, r_exh_tot, r_open_i, r_open_e, r_win_i, r_win_e;
    logic [HW-1:0]       r_head;
    logic [31:0]         r_bucket_start, r_window_start;
    logic [VENT_W-1:0]   r_vent;
    logic [BUCKETS-1:0]  r_valid;
    logic                r_rd_valid;
    logic [33:0]         r_delta;
    logic                r_inh;
    logic [VOL_W+1:0]    r_sum, r_osum;
    logic [23:0]         r_span;

    logic [2*VOL_W-1:0]  rd_data;
    logic [16:0]         n_d;
    logic [15:0]         n_dmag;
    logic [15:0]         n_scale;
    t_div_req            div_req;
    logic                div_done;
    logic [DIVN_W-1:0]   div_quot;
    logic [23:0]         n_mag, n_eff;
    logic [31:0]         n_dt, n_elapsed, n_span;
    logic [VOL_W-1:0]    n_old_i, n_old_e;

    rfvt_ram #(.WIDTH(2*VOL_W), .DEPTH(BUCKETS)) u_ring (
        .i_clk  (i_clk),
        .i_we   (r_state == S_CMT),
        .i_waddr(r_head),
        .i_wdata({r_open_i, r_open_e}),
        .i_raddr(r_head),
        .o_rdata(rd_data)
    );

    rfvt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_comb begin
        n_d     = {1'b0, i_in.raw_sample} - {1'b0, r_zero_offset};
        n_dmag  = n_d[16] ? 16'(-n_d) : n_d[15:0];
        n_scale = (r_flow_scale == '0) ? 16'd1 : r_flow_scale;
        div_req = '0;
        if (r_state == S_IDLE && i_in.valid && !i_in.action) begin
            div_req.start    = 1'b1;
            div_req.iters    = ITER_W'(CONV_ITERS);
            div_req.dividend = {n_dmag, 8'd0, 26'd0};
            div_req.divisor  = {9'd0, n_scale};
        end else if (r_state == S_VST) begin
            div_req.start    = 1'b1;
            div_req.iters    = ITER_W'(DIVN_W);
            div_req.dividend = r_sum[DIVN_W-1:0];
            div_req.divisor  = {r_span, 1'b0};
        end
        n_mag     = (div_quot[23:0] > FLOW_LIMIT) ? FLOW_LIMIT : div_quot[23:0];
        n_eff     = (n_mag < {8'd0, r_deadband}) ? 24'd0 : n_mag;
        n_dt      = r_now - r_last_time;
        n_elapsed = r_now - r_bucket_start;
        n_span    = r_now - r_window_start;
        n_old_i   = r_rd_valid ? rd_data[2*VOL_W-1:VOL_W] : '0;
        n_old_e   = r_rd_valid ? rd_data[VOL_W-1:0] : '0;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = (r_state == S_OUT);
    assign o_out.flow          = r_last_flow;
    assign o_out.inhale_volume = r_inh_tot;
    assign o_out.exhale_volume = r_exh_tot;
    assign o_out.ventilation   = r_vent;
    assign o_out.breath_phase  = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_zero_offset  <= 16'd32768;
            r_flow_scale   <= 16'd120;
            r_phase_thr    <= 16'd512;
            r_deadband     <= 16'd128;
            r_bucket_ms    <= 16'd3750;
            r_window_ms    <= 24'd60000;
            r_primed       <= 1'b0;
            r_last_time    <= '0;
            r_last_flow    <= '0;
            r_phase        <= PHASE_IDLE;
            r_inh_tot      <= '0;
            r_exh_tot      <= '0;
            r_open_i       <= '0;
            r_open_e       <= '0;
            r_win_i        <= '0;
            r_win_e        <= '0;
            r_head         <= '0;
            r_bucket_start <= '0;
            r_window_start <= '0;
            r_vent         <= '0;
            r_valid        <= '0;
            r_rd_valid     <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[r_head];
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ZERO_OFFSET: r_zero_offset <= i_cfg_data[15:0];
                    CFG_FLOW_SCALE:  r_flow_scale  <= i_cfg_data[15:0];
                    CFG_PHASE_THR:   r_phase_thr   <= i_cfg_data[15:0];
                    CFG_DEADBAND:    r_deadband    <= i_cfg_data[15:0];
                    CFG_BUCKET_MS:   r_bucket_ms   <= i_cfg_data[15:0];
                    CFG_WINDOW_MS:   r_window_ms   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_now <= i_in.time_ms;
                        r_neg <= (n_d != '0) && !n_d[16];
                        if (i_in.action) begin
                            r_inh_tot      <= '0;
                            r_exh_tot      <= '0;
                            r_phase        <= PHASE_IDLE;
                            r_primed       <= 1'b0;
                            r_last_time    <= '0;
                            r_valid        <= '0;
                            r_head         <= '0;
                            r_open_i       <= '0;
                            r_open_e       <= '0;
                            r_win_i        <= '0;
                            r_win_e        <= '0;
                            r_bucket_start <= i_in.time_ms;
                            r_window_start <= i_in.time_ms;
                            r_vent         <= '0;
                            r_state        <= S_OUT;
                        end else begin
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    if (div_done) begin
                        r_last_flow <= r_neg ? -$signed({1'b0, n_mag})
                                             : $signed({1'b0, n_mag});
                        r_last_time <= r_now;
                        if (!r_primed) begin
                            r_primed       <= 1'b1;
                            r_valid        <= '0;
                            r_head         <= '0;
                            r_open_i       <= '0;
                            r_open_e       <= '0;
                            r_win_i        <= '0;
                            r_win_e        <= '0;
                            r_bucket_start <= r_now;
                            r_window_start <= r_now;
                            r_vent         <= '0;
                            r_state        <= S_OUT;
                        end else if (n_dt == '0 || n_dt > MAX_GAP_MS) begin
                            r_state <= S_OUT;
                        end else begin
                            r_inh   <= !r_neg;
                            r_delta <= 34'(n_eff * n_dt[9:0]);
                            if (n_eff > {8'd0, r_phase_thr} && n_eff != '0) begin
                                r_phase <= r_neg ? PHASE_EXHALE : PHASE_INHALE;
                            end else if (n_eff < {8'd0, r_deadband}) begin
                                r_phase <= PHASE_IDLE;
                            end
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    if (r_inh) begin
                        r_inh_tot <= sat_add48(r_inh_tot, VOL_W'(r_delta));
                        r_open_i  <= sat_add48(r_open_i, VOL_W'(r_delta));
                    end else begin
                        r_exh_tot <= sat_add48(r_exh_tot, VOL_W'(r_delta));
                        r_open_e  <= sat_add48(r_open_e, VOL_W'(r_delta));
                    end
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (n_elapsed >= {16'd0, r_bucket_ms}) begin
                        r_win_i <= floor_sub48(r_win_i, n_old_i);
                        r_win_e <= floor_sub48(r_win_e, n_old_e);
                        r_state <= S_CMT;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_CMT: begin
                    r_win_i         <= sat_add48(r_win_i, r_open_i);
                    r_win_e         <= sat_add48(r_win_e, r_open_e);
                    r_open_i        <= '0;
                    r_open_e        <= '0;
                    r_valid[r_head] <= 1'b1;
                    r_head          <= (r_head == HW'(BUCKETS - 1)) ? '0 : r_head + 1'b1;
                    r_bucket_start  <= r_now;
                    r_state         <= S_SUM;
                end
                S_SUM: begin
                    if (n_span < {16'd0, r_bucket_ms}) begin
                        r_vent  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        if (n_span > {8'd0, r_window_ms}) begin
                            r_span <= (r_window_ms == '0) ? 24'd1 : r_window_ms;
                        end else begin
                            r_span <= (n_span == '0) ? 24'd1 : n_span[23:0];
                        end
                        r_sum   <= {2'b0, r_win_i} + {2'b0, r_win_e};
                        r_osum  <= {2'b0, r_open_i} + {2'b0, r_open_e};
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_sum   <= r_sum + r_osum;
                    r_state <= S_VST;
                end
                S_VST: begin
                    r_state <= S_VDIV;
                end
                S_VDIV: begin
                    if (div_done) begin
                        r_vent  <= (div_quot > DIVN_W'(MAX_VENT)) ? MAX_VENT
                                                                  : div_quot[VENT_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/rfvt_checker.sv -----
// Port-level checks of the tracker, bound to the top level.
// Depends on respiratory_flow_volume_tracker_unit_assert.svh.
`include "respiratory_flow_volume_tracker_unit_assert.svh"
`timescale 1ns / 1ps
`default_nettype none
module rfvt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_phase
);
    `RFVT_ASSERT_ALWAYS(a_one_item, i_clk, i_rst_n, !(i_in_ready && i_out_valid))
    `RFVT_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !i_in_ready)
    `RFVT_ASSERT_NEXT(a_drop_after_out, i_clk, i_rst_n, i_out_valid && i_out_ready,
        !i_out_valid && i_in_ready)
    `RFVT_ASSERT_ALWAYS(a_phase_code, i_clk, i_rst_n, !i_out_valid || i_phase != 2'd3)
endmodule

bind respiratory_flow_volume_tracker_unit rfvt_checker u_rfvt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_phase    (o_out.breath_phase)
);
`default_nettype wire
